/* rtl/lcte_pkg.sv */
package lcte_pkg;

   // Action codes
   localparam logic [2:0] ACT_LOOKUP    = 3'd0;
   localparam logic [2:0] ACT_INSERT    = 3'd1;
   localparam logic [2:0] ACT_EVICT_LRU = 3'd2;
   localparam logic [2:0] ACT_EVICT_IDX = 3'd3;
   localparam logic [2:0] ACT_EXPIRY    = 3'd4;

   // Status codes
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_TOO_BIG  = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NONE     = 3'd4;

   // Configuration register indexes
   localparam logic CSR_REQUEST_LIMIT  = 1'b0;
   localparam logic CSR_RESPONSE_LIMIT = 1'b1;

   localparam logic [31:0] NO_LIMIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]         action;
      logic [47:0]        key;
      logic [15:0]        request_length;
      logic [19:0]        resp_bytes;
      logic signed [31:0] max_age;
      logic [3:0]         entry_index;
      logic [31:0]        now_seconds;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  found_index;
      logic [19:0] stored_size;
      logic [47:0] evicted_key;
      logic        expired;
      logic [4:0]  valid_count;
   } rsp_type;

endpackage

/* rtl/lru_cache_table_with_expiry.sv */
// Fully associative cache table with LRU eviction and a max-age test.
// A request is taken when start is high and busy is low; busy then stays high
// until the single response strobe (rsp_valid), which the receiver cannot
// stall. Lookup, insert and LRU eviction scan every entry in memory, one per
// cycle through a single read port. Evict by index, expiry check and unused
// actions need one read only. busy drops in the response cycle, so the next
// request can be taken in that cycle; a new request is not taken before the
// response to the last one. Entry stamps live in one memory and the other
// per-entry fields in another; valid bits are flip-flops cleared by reset,
// and invalid entries read a zero stamp. No clearing pass.
module lru_cache_table_with_expiry import lcte_pkg::*; #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LAST = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_ACT  = 3'd4;
   localparam logic [2:0] S_WR   = 3'd5;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [19:0]         size;
      logic [31:0]         ins_time;
      logic [31:0]         max_age;
   } ent_type;

   // Memories
   ent_type     ent_mem [ENTRIES];
   logic [63:0] stamp_mem [ENTRIES];
   ent_type     ent_rd_ff;
   logic [63:0] stamp_rd_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic        ent_we, stamp_we;
   logic [IW-1:0] rd_addr, wr_addr;
   ent_type     ent_wd;
   logic [63:0] stamp_wd;

   // Control registers
   logic [2:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic        sel_ok_ff, sel_ok_in;
   logic [IW-1:0] sel_ff, sel_in;
   logic [63:0] best_ff, best_in;
   logic [KEY_BITS-1:0] bkey_ff, bkey_in;
   logic [63:0] use_ff, use_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [15:0] rlim_ff, rlim_in;
   logic [19:0] slim_ff, slim_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        idx_ok;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign idx_ok    = ({28'd0, req_ff.entry_index} < 32'(ENTRIES));

   // Memory ports
   always_ff @(posedge clock) begin
      if (ent_we)
         ent_mem[wr_addr] <= ent_wd;
      if (stamp_we)
         stamp_mem[wr_addr] <= stamp_wd;
      ent_rd_ff   <= ent_mem[rd_addr];
      stamp_rd_ff <= stamp_mem[rd_addr];
   end

   // Effective read view: invalid entries show a zero stamp
   ent_type     ev;
   logic [63:0] sv;
   logic        vv;
   always_comb begin
      vv = valid_ff[rd_idx_ff];
      ev = ent_rd_ff;
      sv = stamp_rd_ff;
      if (!vv) begin
         sv = '0;
      end
   end

   // Insert time and max-age are kept in memory; for entries never inserted or evicted
   // by index, their reset values (zero and no limit) are emulated through a shadow flag.
   logic [ENTRIES-1:0] touched_ff, touched_in;
   ent_type ev_t;
   always_comb begin
      ev_t = ev;
      if (!touched_ff[rd_idx_ff]) begin
         ev_t.ins_time = '0;
         ev_t.max_age  = NO_LIMIT;
      end
   end

   always_comb begin
      logic [63:0] age, lim;
      state_in = state_ff; req_in = req_ff; scan_in = scan_ff;
      rd_idx_in = rd_idx_ff; sel_ok_in = sel_ok_ff; sel_in = sel_ff;
      best_in = best_ff; bkey_in = bkey_ff; use_in = use_ff; occ_in = occ_ff;
      rlim_in = rlim_ff; slim_in = slim_ff; valid_in = valid_ff;
      touched_in = touched_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      ent_we = 1'b0; stamp_we = 1'b0; wr_addr = sel_ff;
      ent_wd = ev_t; stamp_wd = '0;
      rd_addr = scan_ff;
      age = 64'({32'd0, req_ff.now_seconds}) - 64'({32'd0, ev_t.ins_time});
      lim = {{32{ev_t.max_age[31]}}, ev_t.max_age};

      if (csr_valid) begin
         if (csr_index == CSR_REQUEST_LIMIT) rlim_in = csr_wdata[15:0];
         else                                slim_in = csr_wdata[19:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data; scan_in = '0; rd_addr = '0;
               rd_idx_in = '0; sel_ok_in = 1'b0; sel_in = '0; best_in = '0;
               rd_addr = IW'(req_data.entry_index);
               if (req_data.action == ACT_LOOKUP || req_data.action == ACT_INSERT
                   || req_data.action == ACT_EVICT_LRU) begin
                  rd_addr = '0;
                  state_in = S_SCAN;
                  scan_in = IW'(1);
               end else begin
                  rd_idx_in = IW'(req_data.entry_index);
                  state_in = S_RD;
               end
            end
         end
         S_SCAN, S_LAST: begin
            // examine entry rd_idx_ff, issue read of scan_ff
            rd_addr = scan_ff;
            case (req_ff.action)
               ACT_LOOKUP:
                  if (!sel_ok_ff && vv &&
                      ev.key == KEY_BITS'(req_ff.key)) begin
                     sel_ok_in = 1'b1; sel_in = rd_idx_ff;
                     bkey_in = ev.key; best_in = 64'(ev.size);
                  end
               ACT_INSERT:
                  if (!sel_ok_ff && !vv) begin
                     sel_ok_in = 1'b1; sel_in = rd_idx_ff;
                  end
               default:
                  if (vv && (!sel_ok_ff || sv < best_ff)) begin
                     sel_ok_in = 1'b1; sel_in = rd_idx_ff;
                     best_in = sv; bkey_in = ev.key;
                  end
            endcase
            rd_idx_in = scan_ff;
            if (state_ff == S_LAST) begin
               state_in = S_ACT;
            end else if (32'(scan_ff) == ENTRIES - 1) begin
               state_in = S_LAST;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_RD: begin
            // hold the addressed entry on the read port
            rd_addr = rd_idx_ff;
            state_in = S_ACT;
         end
         S_ACT: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            case (req_ff.action)
               ACT_LOOKUP: begin
                  if (sel_ok_ff) begin
                     use_in = use_ff + 64'd1;
                     stamp_we = 1'b1; stamp_wd = use_in; wr_addr = sel_ff;
                     rsp_in.found_index = 4'(sel_ff);
                     rsp_in.stored_size = best_ff[19:0];
                  end else rsp_in.status = ST_MISS;
               end
               ACT_INSERT: begin
                  if (req_ff.request_length >= rlim_ff ||
                      req_ff.resp_bytes > slim_ff)
                     rsp_in.status = ST_TOO_BIG;
                  else if (!sel_ok_ff)
                     rsp_in.status = ST_FULL;
                  else begin
                     use_in = use_ff + 64'd1;
                     wr_addr = sel_ff; stamp_we = 1'b1; stamp_wd = use_in;
                     ent_we = 1'b1;
                     ent_wd.key = KEY_BITS'(req_ff.key);
                     ent_wd.size = req_ff.resp_bytes;
                     ent_wd.ins_time = req_ff.now_seconds;
                     ent_wd.max_age = req_ff.max_age;
                     valid_in[sel_ff] = 1'b1; touched_in[sel_ff] = 1'b1;
                     occ_in = occ_ff + CW'(1);
                     rsp_in.found_index = 4'(sel_ff);
                  end
               end
               ACT_EVICT_LRU: begin
                  if (!sel_ok_ff) rsp_in.status = ST_NONE;
                  else begin
                     valid_in[sel_ff] = 1'b0;
                     occ_in = occ_ff - CW'(1);
                     rsp_in.found_index = 4'(sel_ff);
                     rsp_in.evicted_key = 48'(bkey_ff);
                  end
               end
               ACT_EVICT_IDX: begin
                  if (!idx_ok) rsp_in.status = ST_NONE;
                  else begin
                     rsp_in.found_index = req_ff.entry_index;
                     if (vv) occ_in = occ_ff - CW'(1);
                     else    rsp_in.status = ST_NONE;
                     valid_in[rd_idx_ff] = 1'b0;
                     touched_in[rd_idx_ff] = 1'b0;
                  end
               end
               ACT_EXPIRY: begin
                  if (idx_ok) begin
                     rsp_in.found_index = req_ff.entry_index;
                     rsp_in.expired = (ev_t.max_age != NO_LIMIT) &&
                                      ($signed(age) >= $signed(lim));
                  end
               end
               default: ;
            endcase
            rsp_in.valid_count = 5'(occ_in);
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; touched_ff <= '0;
         use_ff <= '0; occ_ff <= '0; rlim_ff <= 16'd2048;
         slim_ff <= 20'd102400; rsp_valid_ff <= 1'b0;
         sel_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; touched_ff <= touched_in;
         use_ff <= use_in; occ_ff <= occ_in; rlim_ff <= rlim_in;
         slim_ff <= slim_in; rsp_valid_ff <= rsp_valid_in;
         sel_ok_ff <= sel_ok_in;
      end
      req_ff <= req_in; scan_ff <= scan_in; rd_idx_ff <= rd_idx_in;
      sel_ff <= sel_in; best_ff <= best_in; bkey_ff <= bkey_in; rsp_ff <= rsp_in;
   end

   // Checks
   a_occ: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(valid_ff))
      else $error("occupancy mismatch");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("response while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("double response");

endmodule
